// ===== rtl/spqdk_pkg.sv =====
// Shared types and codes for the sorted priority queue with decrease-key.
`timescale 1ns / 1ps
`default_nettype none

package spqdk_pkg;

  localparam int Q_DEPTH = 1024;
  localparam int MODE_W  = 2;
  localparam int ROW_W   = 10;
  localparam int COL_W   = 10;
  localparam int KEY_W   = 32;
  localparam int STAT_W  = 2;
  localparam int OCC_W   = $clog2(Q_DEPTH + 1);

  localparam logic [MODE_W-1:0] MODE_INSERT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DECREASE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_POP      = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NOP      = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [STAT_W-1:0] ST_MISSING = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ROW_W-1:0]  grid_row;
    logic [COL_W-1:0]  grid_col;
    logic [KEY_W-1:0]  key_in;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ROW_W-1:0]  popped_row;
    logic [COL_W-1:0]  popped_col;
    logic [KEY_W-1:0]  popped_key;
    logic [OCC_W-1:0]  occupancy;
  } out_item_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [KEY_W-1:0] key;
  } entry_t;

  // Command broadcast to every cell
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_CLEAR,
    CMD_FWD,
    CMD_BACK,
    CMD_COMMIT,
    CMD_POP
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t cmd;
    logic      ins;
    entry_t    ent;
  } cell_ctrl_t;

  // Cell to its tail-side neighbor
  typedef struct packed {
    entry_t ent;
    logic   pre;
    logic   in_region;
  } fwd_link_t;

  // Cell to its head-side neighbor
  typedef struct packed {
    entry_t ent;
    logic   run;
    logic   found;
  } bwd_link_t;

endpackage

`default_nettype wire

// ===== rtl/sorted_priority_queue_decrease_key.sv =====
// Top level: sorted priority queue with decrease-key built as a row of cells.
//
//   channel  ports                      handshake
//   command  start, busy, in_data       taken when start high and busy low
//   result   out_valid, out_data        one-cycle strobe, always taken
//
// Pop and the immediate cases (full, empty, no-op) run no scan. Insert runs the
// backward scan, then commits; decrease-key runs the forward and backward scans,
// then commits. The match and shift flags ripple one cell per clock.
// busy stays high until the result strobe; rst_n (synchronous) empties the queue.
// Results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue_decrease_key #(
  parameter int QUEUE_DEPTH = spqdk_pkg::Q_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire spqdk_pkg::in_item_t in_data,
  output logic                     out_valid,
  output spqdk_pkg::out_item_t     out_data
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  spqdk_pkg::cell_ctrl_t ctrl;
  logic [CNT_W-1:0]      count;
  spqdk_pkg::fwd_link_t  fwd_out [QUEUE_DEPTH];
  spqdk_pkg::bwd_link_t  bwd_out [QUEUE_DEPTH];

  spqdk_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .ctrl     (ctrl),
    .count    (count),
    .head     (bwd_out[0].ent),
    .found    (bwd_out[0].found)
  );

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    spqdk_pkg::fwd_link_t lft;
    spqdk_pkg::bwd_link_t rgt;

    if (g == 0) begin : g_head
      assign lft = '0;
    end else begin : g_mid_l
      assign lft = fwd_out[g-1];
    end

    if (g == QUEUE_DEPTH - 1) begin : g_tail
      assign rgt = '0;
    end else begin : g_mid_r
      assign rgt = bwd_out[g+1];
    end

    spqdk_cell #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .IDX        (g)
    ) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .ctrl (ctrl),
      .count(count),
      .lft  (lft),
      .rgt  (rgt),
      .to_r (fwd_out[g]),
      .to_l (bwd_out[g])
    );
  end

endmodule

`default_nettype wire

// ===== rtl/spqdk_cell.sv =====
// One queue slot: holds an entry plus the scan flags that ripple between neighbors.
`timescale 1ns / 1ps
`default_nettype none

module spqdk_cell #(
  parameter int QUEUE_DEPTH = spqdk_pkg::Q_DEPTH,
  parameter int IDX         = 0,
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire spqdk_pkg::cell_ctrl_t ctrl,
  input  wire logic [CNT_W-1:0]      count,
  input  wire spqdk_pkg::fwd_link_t  lft,
  input  wire spqdk_pkg::bwd_link_t  rgt,
  output spqdk_pkg::fwd_link_t       to_r,
  output spqdk_pkg::bwd_link_t       to_l
);

  spqdk_pkg::entry_t ent_r;
  logic              pre_r;   // a match exists at a slot nearer the head
  logic              sh_r;    // slot moves one place toward the tail on commit
  logic              f_r;     // target slot found at or behind this slot

  logic live;
  logic match;
  logic is_m;
  logic le;
  logic in_reg;

  assign live   = CNT_W'(IDX) < count;
  assign match  = live && (ent_r.row == ctrl.ent.row) && (ent_r.col == ctrl.ent.col);
  // insert targets the first free slot, decrease the first matching one
  assign is_m   = ctrl.ins ? (count == CNT_W'(IDX)) : (match && !pre_r);
  assign le     = ent_r.key <= ctrl.ent.key;
  assign in_reg = sh_r | is_m;

  assign to_r.ent       = ent_r;
  assign to_r.pre       = pre_r | match;
  assign to_r.in_region = in_reg;
  assign to_l.ent       = ent_r;
  assign to_l.run       = in_reg;
  assign to_l.found     = f_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_r <= 1'b0;
      sh_r  <= 1'b0;
      f_r   <= 1'b0;
    end else begin
      unique case (ctrl.cmd)
        spqdk_pkg::CMD_CLEAR: begin
          pre_r <= 1'b0;
          sh_r  <= 1'b0;
          f_r   <= 1'b0;
        end
        spqdk_pkg::CMD_FWD: begin
          pre_r <= lft.pre;
        end
        spqdk_pkg::CMD_BACK: begin
          // the run stops at the first key not greater than the new one
          sh_r <= rgt.run & ~le;
          f_r  <= is_m | rgt.found;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.cmd)
      spqdk_pkg::CMD_COMMIT: begin
        if (in_reg) begin
          ent_r <= lft.in_region ? lft.ent : ctrl.ent;
        end
      end
      spqdk_pkg::CMD_POP: begin
        ent_r <= rgt.ent;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/spqdk_ctrl.sv =====
// Sequencer: takes commands, steps the cell row through its scans, issues results.
`timescale 1ns / 1ps
`default_nettype none

module spqdk_ctrl #(
  parameter int QUEUE_DEPTH = spqdk_pkg::Q_DEPTH,
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire spqdk_pkg::in_item_t   in_data,
  output logic                       out_valid,
  output spqdk_pkg::out_item_t       out_data,
  output spqdk_pkg::cell_ctrl_t      ctrl,
  output logic [CNT_W-1:0]           count,
  input  wire spqdk_pkg::entry_t     head,
  input  wire logic                  found
);

  localparam int OCC_W = spqdk_pkg::OCC_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FWD,
    ST_BACK,
    ST_COMMIT,
    ST_POP
  } state_t;

  state_t               state_r;
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     step_r;
  logic                 ins_r;
  spqdk_pkg::entry_t    ent_r;
  logic                 out_valid_r;
  spqdk_pkg::out_item_t out_r;

  logic             accept;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] cnt_dec;

  assign busy      = state_r != ST_IDLE;
  assign accept    = start && !busy;
  assign cnt_inc   = count_r + CNT_W'(ins_r);
  assign cnt_dec   = count_r - CNT_W'(1);
  assign count     = count_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    ctrl.ins = ins_r;
    ctrl.ent = ent_r;
    unique case (state_r)
      ST_IDLE:   ctrl.cmd = accept ? spqdk_pkg::CMD_CLEAR : spqdk_pkg::CMD_HOLD;
      ST_FWD:    ctrl.cmd = spqdk_pkg::CMD_FWD;
      ST_BACK:   ctrl.cmd = spqdk_pkg::CMD_BACK;
      ST_COMMIT: ctrl.cmd = spqdk_pkg::CMD_COMMIT;
      ST_POP:    ctrl.cmd = spqdk_pkg::CMD_POP;
      default:   ctrl.cmd = spqdk_pkg::CMD_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            ins_r            <= in_data.mode == spqdk_pkg::MODE_INSERT;
            ent_r.row        <= in_data.grid_row;
            ent_r.col        <= in_data.grid_col;
            ent_r.key        <= in_data.key_in;
            step_r           <= count_r;
            out_r.popped_row <= '0;
            out_r.popped_col <= '0;
            out_r.popped_key <= '0;
            out_r.occupancy  <= OCC_W'(count_r);
            unique case (in_data.mode)
              spqdk_pkg::MODE_INSERT: begin
                if (count_r == CNT_W'(QUEUE_DEPTH)) begin
                  out_r.status <= spqdk_pkg::ST_FULL;
                  out_valid_r  <= 1'b1;
                end else begin
                  state_r <= ST_BACK;
                end
              end
              spqdk_pkg::MODE_DECREASE: begin
                state_r <= ST_FWD;
              end
              spqdk_pkg::MODE_POP: begin
                if (count_r == '0) begin
                  out_r.status <= spqdk_pkg::ST_EMPTY;
                  out_valid_r  <= 1'b1;
                end else begin
                  state_r <= ST_POP;
                end
              end
              default: begin
                out_r.status <= spqdk_pkg::ST_OK;
                out_valid_r  <= 1'b1;
              end
            endcase
          end
        end
        ST_FWD: begin
          // match-before flags settle one slot per step
          if (step_r == '0) begin
            state_r <= ST_BACK;
            step_r  <= count_r;
          end else begin
            step_r <= step_r - CNT_W'(1);
          end
        end
        ST_BACK: begin
          if (step_r == '0) begin
            state_r <= ST_COMMIT;
          end else begin
            step_r <= step_r - CNT_W'(1);
          end
        end
        ST_COMMIT: begin
          state_r         <= ST_IDLE;
          count_r         <= cnt_inc;
          out_r.status    <= (ins_r || found) ? spqdk_pkg::ST_OK : spqdk_pkg::ST_MISSING;
          out_r.occupancy <= OCC_W'(cnt_inc);
          out_valid_r     <= 1'b1;
        end
        ST_POP: begin
          state_r          <= ST_IDLE;
          count_r          <= cnt_dec;
          out_r.status     <= spqdk_pkg::ST_OK;
          out_r.popped_row <= head.row;
          out_r.popped_col <= head.col;
          out_r.popped_key <= head.key;
          out_r.occupancy  <= OCC_W'(cnt_dec);
          out_valid_r      <= 1'b1;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Testbench for the sorted priority queue with decrease-key: self-checking, random paced.
`timescale 1ns / 1ps

module tb;

  localparam int STALL_LIMIT = 20000;
  localparam int Q_DEPTH     = spqdk_pkg::Q_DEPTH;
  localparam int MODE_W      = spqdk_pkg::MODE_W;
  localparam int ROW_W       = spqdk_pkg::ROW_W;
  localparam int COL_W       = spqdk_pkg::COL_W;
  localparam int KEY_W       = spqdk_pkg::KEY_W;
  localparam int OCC_W       = spqdk_pkg::OCC_W;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  spqdk_pkg::in_item_t  in_data;
  logic                 out_valid;
  spqdk_pkg::out_item_t out_data;

  sorted_priority_queue_decrease_key #(
    .QUEUE_DEPTH(Q_DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the queue contents
  logic [KEY_W-1:0] q_key [Q_DEPTH];
  logic [ROW_W-1:0] q_row [Q_DEPTH];
  logic [COL_W-1:0] q_col [Q_DEPTH];
  int               q_count = 0;

  spqdk_pkg::out_item_t expected_responses[$];
  int                   errors_seen = 0;
  int                   idle_cycles = 0;
  logic                 no_idle = 1'b0;

  function automatic int find_entry(logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
    for (int p = 0; p < q_count; p++) begin
      if (q_row[p] == row && q_col[p] == col) return p;
    end
    return -1;
  endfunction

  // Move an entry toward the head past strictly greater keys
  function automatic void sift_forward(int pos);
    logic [KEY_W-1:0] k;
    logic [ROW_W-1:0] r;
    logic [COL_W-1:0] c;
    while (pos > 0 && q_key[pos-1] > q_key[pos]) begin
      k = q_key[pos-1];
      r = q_row[pos-1];
      c = q_col[pos-1];
      q_key[pos-1] = q_key[pos];
      q_row[pos-1] = q_row[pos];
      q_col[pos-1] = q_col[pos];
      q_key[pos] = k;
      q_row[pos] = r;
      q_col[pos] = c;
      pos--;
    end
  endfunction

  // Apply one command to the shadow queue and return the response it should produce
  function automatic spqdk_pkg::out_item_t advance_queue(spqdk_pkg::in_item_t cmd);
    spqdk_pkg::out_item_t rsp;
    int                   p;
    rsp = '0;
    rsp.status = spqdk_pkg::ST_OK;
    case (cmd.mode)
      spqdk_pkg::MODE_INSERT: begin
        if (q_count >= Q_DEPTH) begin
          rsp.status = spqdk_pkg::ST_FULL;
        end else begin
          q_key[q_count] = cmd.key_in;
          q_row[q_count] = cmd.grid_row;
          q_col[q_count] = cmd.grid_col;
          q_count++;
          sift_forward(q_count - 1);
        end
      end
      spqdk_pkg::MODE_DECREASE: begin
        p = find_entry(cmd.grid_row, cmd.grid_col);
        if (p < 0) begin
          rsp.status = spqdk_pkg::ST_MISSING;
        end else begin
          q_key[p] = cmd.key_in;
          sift_forward(p);
        end
      end
      spqdk_pkg::MODE_POP: begin
        if (q_count == 0) begin
          rsp.status = spqdk_pkg::ST_EMPTY;
        end else begin
          rsp.popped_row = q_row[0];
          rsp.popped_col = q_col[0];
          rsp.popped_key = q_key[0];
          for (p = 1; p < q_count; p++) begin
            q_key[p-1] = q_key[p];
            q_row[p-1] = q_row[p];
            q_col[p-1] = q_col[p];
          end
          q_count--;
        end
      end
      default: ;
    endcase
    rsp.occupancy = OCC_W'(q_count);
    return rsp;
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3, 4: return KEY_W'($urandom_range(0, 15));  // ties
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [ROW_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return ROW_W'($urandom_range(0, 3));  // duplicate coordinates
      default: return ROW_W'($urandom_range(0, 1023));
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // One command transaction; the expectation is recorded at the accepting edge
  task automatic send_cmd(input logic [MODE_W-1:0] mode, input logic [ROW_W-1:0] row,
                          input logic [COL_W-1:0] col, input logic [KEY_W-1:0] key);
    spqdk_pkg::in_item_t cmd;
    int                  n;
    cmd.mode     = mode;
    cmd.grid_row = row;
    cmd.grid_col = col;
    cmd.key_in   = key;
    n = no_idle ? 0 : pick_gap();
    if (n > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
    @(negedge clk);
    start   <= 1'b1;
    in_data <= cmd;
    do @(posedge clk); while (busy);
    expected_responses.push_back(advance_queue(cmd));
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    start <= 1'b0;
    while (expected_responses.size() != 0) @(posedge clk);
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors_seen++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_responses.size() == 0) begin
        $error("response with no transaction outstanding");
        errors_seen++;
      end else begin
        spqdk_pkg::out_item_t want;
        want = expected_responses.pop_front();
        check_field("status", 32'(want.status), 32'(out_data.status));
        check_field("popped_row", 32'(want.popped_row), 32'(out_data.popped_row));
        check_field("popped_col", 32'(want.popped_col), 32'(out_data.popped_col));
        check_field("popped_key", want.popped_key, out_data.popped_key);
        check_field("occupancy", 32'(want.occupancy), 32'(out_data.occupancy));
      end
    end
  end

  // Watchdog on cycles with no transaction in either direction
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("Regression FAIL");
          $finish;
        end
      end
    end
  end

  task automatic test_empty_queue();
    send_cmd(spqdk_pkg::MODE_POP, '0, '0, '0);
    send_cmd(spqdk_pkg::MODE_DECREASE, 10'd5, 10'd5, 32'd9);
    send_cmd(spqdk_pkg::MODE_NOP, '1, '1, '1);
  endtask

  task automatic test_insert_order();
    send_cmd(spqdk_pkg::MODE_INSERT, '1, '0, '1);
    send_cmd(spqdk_pkg::MODE_INSERT, '0, '1, '0);
    send_cmd(spqdk_pkg::MODE_INSERT, 10'd3, 10'd4, 32'd5);
    send_cmd(spqdk_pkg::MODE_INSERT, 10'd4, 10'd3, 32'd5);  // equal key stays behind
    send_cmd(spqdk_pkg::MODE_INSERT, 10'd7, 10'd7, 32'd200);
    send_cmd(spqdk_pkg::MODE_INSERT, 10'd7, 10'd7, 32'd100);
  endtask

  task automatic test_decrease_key();
    send_cmd(spqdk_pkg::MODE_DECREASE, 10'd7, 10'd7, 32'd1);    // first match from head
    send_cmd(spqdk_pkg::MODE_DECREASE, '0, '1, 32'hFFFF_FFFE);  // larger key, left in place
    send_cmd(spqdk_pkg::MODE_DECREASE, '1, '0, 32'd5);
    send_cmd(spqdk_pkg::MODE_DECREASE, 10'd9, 10'd9, 32'd0);    // not present
    send_cmd(spqdk_pkg::MODE_NOP, '0, '0, '0);
  endtask

  task automatic test_drain();
    while (q_count > 0) send_cmd(spqdk_pkg::MODE_POP, '0, '0, '0);
    send_cmd(spqdk_pkg::MODE_POP, '1, '1, '1);
  endtask

  task automatic test_random_traffic(input int n_items);
    int               sel;
    int               ins_limit;
    int               p;
    logic [KEY_W-1:0] k;
    for (int i = 0; i < n_items; i++) begin
      if (i % 60 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (i % 150 == 75) wait_for_results();
      ins_limit = (q_count > 40) ? 20 : 42;
      sel = $urandom_range(0, 99);
      if (sel < ins_limit) begin
        send_cmd(spqdk_pkg::MODE_INSERT, rand_coord(), rand_coord(), rand_key());
      end else if (sel < 62 && q_count > 0) begin
        p = $urandom_range(0, q_count - 1);
        k = ($urandom_range(0, 3) == 0) ? rand_key() : KEY_W'($urandom_range(0, q_key[p]));
        send_cmd(spqdk_pkg::MODE_DECREASE, q_row[p], q_col[p], k);
      end else if (sel < 69) begin
        send_cmd(spqdk_pkg::MODE_DECREASE, rand_coord(), rand_coord(), rand_key());
      end else if (sel < 94) begin
        send_cmd(spqdk_pkg::MODE_POP, rand_coord(), rand_coord(), rand_key());
      end else begin
        send_cmd(spqdk_pkg::MODE_NOP, rand_coord(), rand_coord(), rand_key());
      end
    end
    no_idle = 1'b0;
  endtask

  task automatic test_full_queue();
    int               i;
    int               p;
    logic [ROW_W-1:0] r;
    logic [COL_W-1:0] c;
    i = 0;
    while (q_count < Q_DEPTH) begin
      if (i % 80 == 0) no_idle = ($urandom_range(0, 2) == 0);
      send_cmd(spqdk_pkg::MODE_INSERT, rand_coord(), rand_coord(), rand_key());
      i++;
    end
    no_idle = 1'b0;
    send_cmd(spqdk_pkg::MODE_INSERT, '1, '1, '0);
    send_cmd(spqdk_pkg::MODE_INSERT, '0, '0, '1);
    p = Q_DEPTH - 1;
    send_cmd(spqdk_pkg::MODE_DECREASE, q_row[p], q_col[p], '0);
    do begin
      r = ROW_W'($urandom_range(0, 1023));
      c = COL_W'($urandom_range(0, 1023));
    end while (find_entry(r, c) >= 0);
    send_cmd(spqdk_pkg::MODE_DECREASE, r, c, rand_key());
    p = $urandom_range(0, Q_DEPTH - 1);
    send_cmd(spqdk_pkg::MODE_DECREASE, q_row[p], q_col[p], '1);
    send_cmd(spqdk_pkg::MODE_NOP, rand_coord(), rand_coord(), rand_key());
    wait_for_results();
    for (i = 0; i < 40; i++) begin
      send_cmd(spqdk_pkg::MODE_POP, rand_coord(), rand_coord(), rand_key());
    end
    for (i = 0; i < 10; i++) begin
      send_cmd(spqdk_pkg::MODE_INSERT, rand_coord(), rand_coord(), rand_key());
    end
    for (i = 0; i < 10; i++) begin
      send_cmd(spqdk_pkg::MODE_POP, rand_coord(), rand_coord(), rand_key());
    end
  endtask

  initial begin
    start   = 1'b0;
    in_data = '0;
    rst_n   = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_queue();
    test_insert_order();
    test_decrease_key();
    test_drain();
    test_random_traffic(600);
    test_full_queue();

    wait_for_results();
    repeat (2 * Q_DEPTH + 8) @(posedge clk);
    if (errors_seen == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
